FILE: sv/wss_pkg.sv
// shared types and constants for the word shell sort block
`default_nettype none
package wss_pkg;

	localparam int MAX_WORDS_DEF  = 64;
	localparam int WORD_CHARS_DEF = 8;
	localparam int WORD_W         = 64;
	localparam int COUNT_W        = 16;

	typedef struct packed {
		logic [WORD_W-1:0] word_in;
		logic              final_word;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word_out;
		logic               end_of_run;
		logic [COUNT_W-1:0] shift_count;
		logic [COUNT_W-1:0] move_count;
		logic               overflow_flag;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic grow;
		logic pass_init;
		logic fetch;
		logic hold;
		logic probe;
		logic place;
		logic shrink;
		logic emit_rd;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic grow_ok;
		logic pos_lt_n;
		logic gap_one;
		logic greater;
		logic deep;
		logic emit_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/wss_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module wss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/wss_ctrl.sv
// sequencer for load, gap setup, insertion passes and read out
`default_nettype none
module wss_ctrl
	import wss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic final_word,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GROW,
		S_PASS,
		S_HOLD,
		S_CMP,
		S_PLACE,
		S_EMIT,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (final_word) state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (sts.grow_ok) begin
					cmd.grow = 1'b1;
				end else begin
					cmd.pass_init = 1'b1;
					state_d       = S_PASS;
				end
			end
			S_PASS: begin
				if (sts.pos_lt_n) begin
					cmd.fetch = 1'b1;
					state_d   = S_HOLD;
				end else if (sts.gap_one) begin
					state_d = S_EMIT;
				end else begin
					cmd.shrink = 1'b1;
				end
			end
			S_HOLD: begin
				cmd.hold = 1'b1;
				state_d  = S_CMP;
			end
			S_CMP: begin
				if (sts.greater) begin
					cmd.probe = 1'b1;
					if (!sts.deep) state_d = S_PLACE;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_PASS;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_PASS;
			end
			S_EMIT: begin
				cmd.emit_rd = 1'b1;
				if (sts.emit_last) state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: sv/wss_dp.sv
// word store, gap and index registers, counters and result formatting
`default_nettype none
module wss_dp
	import wss_pkg::*;
#(
	parameter int MAX_WORDS  = MAX_WORDS_DEF,
	parameter int WORD_CHARS = WORD_CHARS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire cmd_t  cmd,
	output sts_t       sts,
	output logic       strobe,
	output result_t    result
);

	localparam int AW = $clog2(MAX_WORDS);
	localparam int NW = $clog2(MAX_WORDS + 1);
	localparam int PW = NW + 9;
	localparam logic [WORD_W-1:0] KEEP_MASK = {WORD_W{1'b1}} << (8 * (8 - WORD_CHARS));

	logic [NW-1:0]      total_q, gap_q, pos_q, slot_q, k_q;
	logic               dropped_q, end_s1;
	logic [WORD_W-1:0]  held_q;
	logic [COUNT_W-1:0] shift_q, move_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	logic [NW+1:0] gap3;
	logic [PW-1:0] shrink_prod;
	logic [NW-1:0] gap_next;
	logic [NW-1:0] slot_up;
	logic [NW-1:0] pos_back, slot_back;
	logic          room;

	wss_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign room = (total_q < NW'(MAX_WORDS));
	assign gap3 = ({2'b00, gap_q} << 1) + {2'b00, gap_q};
	// (gap - 1) / 3 as a reciprocal multiply, exact for these narrow gaps
	assign shrink_prod = PW'(gap_q - NW'(1)) * PW'(171);
	assign gap_next    = NW'(shrink_prod >> 9);
	assign slot_up     = slot_q - gap_q;
	assign pos_back    = pos_q - gap_q;
	assign slot_back   = slot_up - gap_q;

	always_comb begin
		we    = 1'b0;
		waddr = slot_q[AW-1:0];
		wdata = held_q;
		if (cmd.load) begin
			we    = room;
			waddr = total_q[AW-1:0];
			wdata = item.word_in & KEEP_MASK;
		end else if (cmd.probe) begin
			we    = 1'b1;
			wdata = rdata;
		end else if (cmd.place) begin
			we = 1'b1;
		end
	end

	always_comb begin
		raddr = k_q[AW-1:0];
		if (cmd.fetch) begin
			raddr = pos_q[AW-1:0];
		end else if (cmd.hold) begin
			raddr = pos_back[AW-1:0];
		end else if (cmd.probe) begin
			raddr = slot_back[AW-1:0];
		end
	end

	assign sts.grow_ok   = (gap3 + (NW+2)'(2)) < {2'b00, total_q};
	assign sts.pos_lt_n  = (pos_q < total_q);
	assign sts.gap_one   = (gap_q == NW'(1));
	assign sts.greater   = (rdata > held_q);
	assign sts.deep      = ({1'b0, slot_q} >= {gap_q, 1'b0});
	assign sts.emit_last = (k_q == total_q - NW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			dropped_q <= 1'b0;
			strobe    <= 1'b0;
		end else begin
			strobe <= cmd.emit_rd;
			if (cmd.load) begin
				if (room) total_q <= total_q + NW'(1);
				else      dropped_q <= 1'b1;
			end
			if (cmd.finish) begin
				total_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		end_s1 <= sts.emit_last;
		if (cmd.load && item.final_word) begin
			gap_q   <= NW'(1);
			k_q     <= '0;
			shift_q <= '0;
			move_q  <= '0;
		end
		if (cmd.grow) gap_q <= NW'(gap3 + (NW+2)'(1));
		if (cmd.pass_init) pos_q <= gap_q;
		if (cmd.shrink) begin
			gap_q <= gap_next;
			pos_q <= gap_next;
		end
		if (cmd.hold) begin
			held_q <= rdata;
			slot_q <= pos_q;
			if (move_q != '1) move_q <= move_q + COUNT_W'(1);
		end
		if (cmd.probe) begin
			slot_q <= slot_up;
			if (shift_q != '1) shift_q <= shift_q + COUNT_W'(1);
		end
		if (cmd.place) begin
			pos_q <= pos_q + NW'(1);
			if (move_q != '1) move_q <= move_q + COUNT_W'(1);
		end
		if (cmd.emit_rd) k_q <= k_q + NW'(1);
	end

	assign result.word_out      = rdata;
	assign result.end_of_run    = end_s1;
	assign result.shift_count   = shift_q;
	assign result.move_count    = move_q;
	assign result.overflow_flag = dropped_q;

`ifndef ASSERT_OFF
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= NW'(MAX_WORDS))
		else $error("word count above capacity");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe || cmd.place) |-> (slot_q < total_q))
		else $error("sort write outside stored words");
	a_probe_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> (slot_q >= gap_q))
		else $error("shift below start of store");
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && end_s1) |=> (total_q == '0 && !dropped_q))
		else $error("run state not cleared after last beat");
`endif

endmodule
`default_nettype wire

FILE: sv/word_shell_sort.sv
// a word beat is taken on each start in idle; non-final words give no result
// after the final word: gap setup, then per insertion fetch, hold, compare, shifts
// and place, shrink per pass end, then one sorted word per cycle with strobe high
// busy stays high from the final word until the last result beat, set by the
// single read port of the word store that every step goes through
// reset clears word count, overflow and sequencer; store contents are not cleared
`default_nettype none
module word_shell_sort
	import wss_pkg::*;
#(
	parameter int MAX_WORDS  = MAX_WORDS_DEF,
	parameter int WORD_CHARS = WORD_CHARS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       strobe,
	output result_t    result
);

	cmd_t cmd;
	sts_t sts;

	wss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.final_word(item.final_word),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	wss_dp #(
		.MAX_WORDS (MAX_WORDS),
		.WORD_CHARS(WORD_CHARS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.strobe(strobe),
		.result(result)
	);

endmodule
`default_nettype wire
